/* hw/rtl/rlcc_pkg.sv */
// Shared types and constants for the region log coverage checker.
package rlcc_pkg;

    localparam int LOG_DEPTH_DEF = 1024;

    localparam logic [3:0] OP_ADD_ALLOC = 4'd0;
    localparam logic [3:0] OP_ADD_OWN   = 4'd1;
    localparam logic [3:0] OP_CHK_COV   = 4'd2;
    localparam logic [3:0] OP_CHK_OWN   = 4'd3;
    localparam logic [3:0] OP_CLR_ALLOC = 4'd4;
    localparam logic [3:0] OP_CLR_OWN   = 4'd5;
    localparam logic [3:0] OP_SAV_ALLOC = 4'd6;
    localparam logic [3:0] OP_SAV_OWN   = 4'd7;
    localparam logic [3:0] OP_RST_ALLOC = 4'd8;
    localparam logic [3:0] OP_RST_OWN   = 4'd9;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MARK = 2'd2;
    localparam logic [1:0] ST_OVER = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_WAIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       simple;     // non-walk op on the transaction in hand
        logic       walk_init;  // load query and start a log walk
        logic       issue;      // read the next log entry
        logic [3:0] op;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic alloc_empty;
        logic owner_empty;
        logic idx_zero;
        logic walk_done;
    } t_sts;

endpackage

/* hw/rtl/rlcc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rlcc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/rlcc_dp.sv */
// Datapath: log RAMs, entry counts, overlap pipeline and remainder accumulator.
module rlcc_dp import rlcc_pkg::*; #(
    parameter int LOG_DEPTH = LOG_DEPTH_DEF,
    localparam int IDX_W = $clog2(LOG_DEPTH),
    localparam int CNT_W = $clog2(LOG_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [63:0]      i_address,
    input  logic [63:0]      i_length,
    output t_sts             o_sts,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic             o_verdict,
    output logic [CNT_W-1:0] o_mark
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LOG_DEPTH);

    // counts and control
    logic [CNT_W-1:0] r_alloc_cnt, n_alloc_cnt;
    logic [CNT_W-1:0] r_own_cnt, n_own_cnt;
    logic             r_stop;
    logic             r_v0, r_v1, r_v2, r_v3;
    logic             r_res_v, n_res_v;

    // walk payload
    logic             r_own;
    logic [63:0]      r_qa;
    logic [64:0]      r_qend;
    logic [63:0]      r_rem;
    logic [IDX_W-1:0] r_idx;
    logic             r_l0, r_l1, r_l2, r_l3;
    logic [64:0]      r_rend;
    logic [63:0]      r_lb1;
    logic [64:0]      r_ub;
    logic [63:0]      r_lb2;
    logic [63:0]      r_ov;

    // result payload
    logic [1:0]       r_status, n_status;
    logic             r_verdict, n_verdict;
    logic [CNT_W-1:0] r_mark, n_mark;

    logic             we_alloc, we_own;
    logic [127:0]     alloc_rdata, own_rdata, rdata;
    logic [63:0]      ra, rl, lb;
    logic [64:0]      ub;
    logic [CNT_W-1:0] sel_cnt;
    logic             acc_v, over, hit, walk_done, walk_verdict;
    logic [1:0]       walk_status;
    logic [63:0]      rem_sub;

    rlcc_ram #(.WIDTH(128), .DEPTH(LOG_DEPTH)) u_alloc_ram (
        .i_clk   (i_clk),
        .i_we    (we_alloc),
        .i_waddr (r_alloc_cnt[IDX_W-1:0]),
        .i_wdata ({i_address, i_length}),
        .i_raddr (r_idx),
        .o_rdata (alloc_rdata)
    );

    rlcc_ram #(.WIDTH(128), .DEPTH(LOG_DEPTH)) u_own_ram (
        .i_clk   (i_clk),
        .i_we    (we_own),
        .i_waddr (r_own_cnt[IDX_W-1:0]),
        .i_wdata ({i_address, i_length}),
        .i_raddr (r_idx),
        .o_rdata (own_rdata)
    );

    // overlap pipeline datapath
    assign rdata = r_own ? own_rdata : alloc_rdata;
    assign ra    = rdata[127:64];
    assign rl    = rdata[63:0];
    assign lb    = (ra > r_qa) ? ra : r_qa;
    assign ub    = (r_qend < r_rend) ? r_qend : r_rend;

    // accumulator stage
    assign acc_v   = r_v3 && !r_stop;
    assign over    = r_ov > r_rem;
    assign rem_sub = r_rem - r_ov;
    assign hit     = (rem_sub == 64'd0);

    always_comb begin
        walk_done    = 1'b0;
        walk_status  = ST_OK;
        walk_verdict = 1'b0;
        if (acc_v) begin
            if (r_own) begin
                if (r_ov != 64'd0) begin
                    walk_done = 1'b1;
                end else if (r_l3) begin
                    walk_done    = 1'b1;
                    walk_verdict = 1'b1;
                end
            end else begin
                priority if (over) begin
                    walk_done   = 1'b1;
                    walk_status = ST_OVER;
                end else if (hit) begin
                    walk_done    = 1'b1;
                    walk_verdict = 1'b1;
                end else if (r_l3) begin
                    walk_done = 1'b1;
                end
            end
        end
    end

    assign sel_cnt = (i_cmd.op == OP_CHK_OWN) ? r_own_cnt : r_alloc_cnt;

    // operations that need no log walk
    always_comb begin
        n_alloc_cnt = r_alloc_cnt;
        n_own_cnt   = r_own_cnt;
        we_alloc    = 1'b0;
        we_own      = 1'b0;
        n_res_v     = walk_done;
        n_status    = walk_status;
        n_verdict   = walk_verdict;
        n_mark      = '0;
        if (i_cmd.simple) begin
            n_res_v   = 1'b1;
            n_status  = ST_OK;
            n_verdict = 1'b0;
            unique case (i_cmd.op)
                OP_ADD_ALLOC: begin
                    if (r_alloc_cnt >= CNT_MAX) begin
                        n_status = ST_FULL;
                    end else begin
                        we_alloc    = 1'b1;
                        n_alloc_cnt = r_alloc_cnt + CNT_W'(1);
                    end
                end
                OP_ADD_OWN: begin
                    if (r_own_cnt >= CNT_MAX) begin
                        n_status = ST_FULL;
                    end else begin
                        we_own    = 1'b1;
                        n_own_cnt = r_own_cnt + CNT_W'(1);
                    end
                end
                OP_CHK_COV:   n_verdict = 1'b0;  // empty log
                OP_CHK_OWN:   n_verdict = 1'b1;  // empty log
                OP_CLR_ALLOC: n_alloc_cnt = '0;
                OP_CLR_OWN:   n_own_cnt = '0;
                OP_SAV_ALLOC: n_mark = r_alloc_cnt;
                OP_SAV_OWN:   n_mark = r_own_cnt;
                OP_RST_ALLOC: begin
                    if (i_address < 64'(LOG_DEPTH)) begin
                        n_alloc_cnt = i_address[CNT_W-1:0];
                    end else begin
                        n_status = ST_MARK;
                    end
                end
                OP_RST_OWN: begin
                    if (i_address < 64'(LOG_DEPTH)) begin
                        n_own_cnt = i_address[CNT_W-1:0];
                    end else begin
                        n_status = ST_MARK;
                    end
                end
                default: n_status = ST_OK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc_cnt <= '0;
            r_own_cnt   <= '0;
            r_stop      <= 1'b0;
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_res_v     <= 1'b0;
        end else begin
            r_alloc_cnt <= n_alloc_cnt;
            r_own_cnt   <= n_own_cnt;
            r_res_v     <= n_res_v;
            if (i_cmd.walk_init) begin
                r_stop <= 1'b0;
                r_v0   <= 1'b0;
                r_v1   <= 1'b0;
                r_v2   <= 1'b0;
                r_v3   <= 1'b0;
            end else begin
                r_stop <= r_stop | walk_done;
                r_v0   <= i_cmd.issue;
                r_v1   <= r_v0;
                r_v2   <= r_v1;
                r_v3   <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_own  <= (i_cmd.op == OP_CHK_OWN);
            r_qa   <= i_address;
            r_qend <= {1'b0, i_address} + {1'b0, i_length};
            r_rem  <= i_length;
            r_idx  <= IDX_W'(sel_cnt - CNT_W'(1));
        end else begin
            if (i_cmd.issue) begin
                r_idx <= r_idx - IDX_W'(1);
            end
            if (acc_v && !r_own && !over) begin
                r_rem <= rem_sub;
            end
        end
        r_l0   <= (r_idx == '0);
        r_l1   <= r_l0;
        r_rend <= {1'b0, ra} + {1'b0, rl};
        r_lb1  <= lb;
        r_l2   <= r_l1;
        r_ub   <= ub;
        r_lb2  <= r_lb1;
        r_l3   <= r_l2;
        r_ov   <= (r_ub <= {1'b0, r_lb2}) ? 64'd0 : 64'(r_ub - {1'b0, r_lb2});
        r_status  <= n_status;
        r_verdict <= n_verdict;
        r_mark    <= n_mark;
    end

    assign o_sts.alloc_empty = (r_alloc_cnt == '0);
    assign o_sts.owner_empty = (r_own_cnt == '0);
    assign o_sts.idx_zero    = (r_idx == '0);
    assign o_sts.walk_done   = walk_done;

    assign o_valid   = r_res_v;
    assign o_status  = r_status;
    assign o_verdict = r_verdict;
    assign o_mark    = r_mark;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_alloc_cnt <= CNT_MAX) && (r_own_cnt <= CNT_MAX))
        else $error("log count above capacity");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_done |=> o_valid)
        else $error("walk finished without a result strobe");

    a_over_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OVER) |-> !o_verdict)
        else $error("overcount reported with a positive verdict");

endmodule

/* hw/rtl/rlcc_ctrl.sv */
// Controller: accepts transactions and sequences log walks.
module rlcc_ctrl import rlcc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [3:0] i_opcode,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state r_state, n_state;
    logic   is_walk;

    assign is_walk = ((i_opcode == OP_CHK_COV) && !i_sts.alloc_empty) ||
                     ((i_opcode == OP_CHK_OWN) && !i_sts.owner_empty);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && is_walk) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                priority if (i_sts.walk_done) begin
                    n_state = S_IDLE;
                end else if (i_sts.idx_zero) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_sts.walk_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.simple    = 1'b0;
        o_cmd.walk_init = 1'b0;
        o_cmd.issue     = 1'b0;
        o_cmd.op        = i_opcode;
        o_busy          = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy          = 1'b0;
                o_cmd.simple    = i_start && !is_walk;
                o_cmd.walk_init = i_start && is_walk;
            end
            S_WALK:  o_cmd.issue = 1'b1;
            S_WAIT:  o_cmd.issue = 1'b0;
            default: o_cmd.issue = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (!o_cmd.simple && !o_cmd.walk_init))
        else $error("operation started while busy");

    a_init_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.walk_init |=> (r_state == S_WALK))
        else $error("walk start did not enter walk state");

    a_last_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && i_sts.idx_zero && !i_sts.walk_done) |=> (r_state == S_WAIT))
        else $error("reads continued past the oldest entry");

endmodule

/* hw/rtl/region_log_coverage_checker.sv */
// Region log coverage checker top: result timing, throughput and reset.
// Append, clear, save, restore and checks on an empty log: result in the cycle after
//   acceptance with busy low, so one transaction per cycle.
// Check over N entries: one log read per cycle through a four-stage overlap pipeline;
//   result registered from the accumulator stage, busy high until the result cycle.
// Sync active-low reset empties both logs, not the RAMs; one-cycle o_valid, no stall.
module region_log_coverage_checker import rlcc_pkg::*; #(
    parameter int LOG_DEPTH = LOG_DEPTH_DEF,
    localparam int CNT_W = $clog2(LOG_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [3:0]       i_opcode,
    input  logic [63:0]      i_address,
    input  logic [63:0]      i_length,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic             o_verdict,
    output logic [CNT_W-1:0] o_mark
);

    t_cmd cmd;
    t_sts sts;

    rlcc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    rlcc_dp #(.LOG_DEPTH(LOG_DEPTH)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_address (i_address),
        .i_length  (i_length),
        .o_sts     (sts),
        .o_valid   (o_valid),
        .o_status  (o_status),
        .o_verdict (o_verdict),
        .o_mark    (o_mark)
    );

endmodule
